// ----- design/pidl_pkg.sv -----
// Package for the positional insert/delete list.
// Holds sizes, derived widths and operation codes; no dependencies.
`default_nettype none

package pidl_pkg;

    // Store geometry
    localparam int DEPTH       = 256;
    localparam int ENTRY_WIDTH = 64;

    // Fixed port field widths
    localparam int OP_W   = 2;
    localparam int POS_W  = 9;
    localparam int CNT_W  = 9;
    localparam int CAP_W  = 9;
    localparam int WORD_W = 64;
    localparam int NLEN_W = 9;

    // Derived widths
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int MAXW_A = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int MAXW_B = (MAXW_A > CAP_W) ? MAXW_A : CAP_W;
    localparam int CMP_W  = MAXW_B + 1;   // room for pos + cnt

    typedef logic [ENTRY_WIDTH-1:0] entry_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [CMP_W-1:0]       cmp_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

endpackage : pidl_pkg

`default_nettype wire

// ----- design/positional_insert_delete_list.sv -----
// Positional insert/delete list: top level, sequencer and entry memory.
// Depends on pidl_pkg for sizes, types and operation codes.
`default_nettype none

//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  cfg     | cfg_wr_en, cfg_wr_data (capacity)             | in
//  s_      | s_valid/s_ready, operation, position, count,  | in
//          | entry_value                                   |
//  m_      | m_valid/m_ready, accepted, read_value,        | out
//          | new_length                                    |
//
// An insert moves (length - position) entries, a delete (length - position - count)
// entries, or none when count is 0. The single memory port pair moves one entry
// per cycle (read one, write the previous).
// Reset (aresetn low, synchronous) empties the list, sets capacity 256.
// One word is in work at a time; s_ready is high only when idle.
// A finished result waits in the m_ output register; the block can take
// the next word meanwhile but holds its result until m_ is free.

module positional_insert_delete_list (
    input  wire                            aclk,
    input  wire                            aresetn,
    // configuration
    input  wire                            cfg_wr_en,
    input  wire [pidl_pkg::CAP_W-1:0]      cfg_wr_data,
    // input channel
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire [pidl_pkg::OP_W-1:0]       s_operation,
    input  wire [pidl_pkg::POS_W-1:0]      s_position,
    input  wire [pidl_pkg::CNT_W-1:0]      s_count,
    input  wire [pidl_pkg::WORD_W-1:0]     s_entry_value,
    // result channel
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic                           m_accepted,
    output logic [pidl_pkg::WORD_W-1:0]    m_read_value,
    output logic [pidl_pkg::NLEN_W-1:0]    m_new_length
);
    import pidl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SHIFT,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    // Control state
    state_t             state_reg,  state_next;
    len_t               len_reg,    len_next;
    logic [CAP_W-1:0]   cap_reg;
    len_t               moves_reg,  moves_next;
    logic               pend_reg,   pend_next;
    logic               mvalid_reg, mvalid_next;

    // Payload state
    op_t                op_reg,     op_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    entry_t             val_reg,    val_next;
    addr_t              src_reg,    src_next;
    addr_t              dst_reg,    dst_next;
    logic               acc_reg,    acc_next;
    entry_t             rd_reg,     rd_next;
    logic               macc_reg,   macc_next;
    logic [WORD_W-1:0]  mrd_reg,    mrd_next;
    logic [NLEN_W-1:0]  mlen_reg,   mlen_next;

    // Entry memory
    entry_t             mem [DEPTH];
    entry_t             rdata_reg;
    logic               mem_we;
    addr_t              mem_waddr;
    entry_t             mem_wdata;
    addr_t              mem_raddr;

    // Bounds checks, all in one wide compare domain
    cmp_t               len_w, pos_w, cnt_w, cap_w, eff_cap, end_w;
    logic               ins_ok, del_ok, rd_ok;

    always_comb begin
        len_w   = CMP_W'(len_reg);
        pos_w   = CMP_W'(pos_reg);
        cnt_w   = CMP_W'(cnt_reg);
        cap_w   = CMP_W'(cap_reg);
        eff_cap = (cap_w > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_w;
        end_w   = pos_w + cnt_w;
        ins_ok  = (len_w < eff_cap) && (pos_w <= len_w);
        del_ok  = (end_w <= len_w);
        rd_ok   = (pos_w < len_w);
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = mvalid_reg;
    assign m_accepted   = macc_reg;
    assign m_read_value = mrd_reg;
    assign m_new_length = mlen_reg;

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        moves_next  = moves_reg;
        pend_next   = 1'b0;
        mvalid_next = mvalid_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        acc_next    = acc_reg;
        rd_next     = rd_reg;
        macc_next   = macc_reg;
        mrd_next    = mrd_reg;
        mlen_next   = mlen_reg;
        mem_we      = 1'b0;
        mem_waddr   = dst_reg;
        mem_wdata   = rdata_reg;
        mem_raddr   = src_reg;

        if (m_ready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = op_t'(s_operation);
                    pos_next   = s_position;
                    cnt_next   = s_count;
                    val_next   = s_entry_value[ENTRY_WIDTH-1:0];
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK: begin
                // read port aimed at the item position for a read op
                mem_raddr = pos_reg[ADDR_W-1:0];
                rd_next   = '0;
                acc_next  = 1'b0;
                unique case (op_reg)
                    OP_INSERT: begin
                        if (ins_ok) begin
                            acc_next   = 1'b1;
                            src_next   = ADDR_W'(len_reg - len_t'(1));
                            moves_next = LEN_W'(len_w - pos_w);
                            state_next = ST_SHIFT;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_DELETE: begin
                        if (del_ok) begin
                            acc_next   = 1'b1;
                            src_next   = ADDR_W'(end_w);
                            moves_next = (cnt_reg == '0) ? '0 : LEN_W'(len_w - end_w);
                            state_next = ST_SHIFT;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_READ: begin
                        acc_next   = rd_ok;
                        state_next = rd_ok ? ST_RDWAIT : ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SHIFT: begin
                // write the word fetched last cycle
                if (pend_reg) begin
                    mem_we = 1'b1;
                end
                if (moves_reg != '0) begin
                    // fetch the next word to move
                    mem_raddr  = src_reg;
                    pend_next  = 1'b1;
                    moves_next = moves_reg - len_t'(1);
                    if (op_reg == OP_INSERT) begin
                        dst_next = src_reg + addr_t'(1);
                        src_next = src_reg - addr_t'(1);
                    end else begin
                        dst_next = src_reg - ADDR_W'(cnt_reg);
                        src_next = src_reg + addr_t'(1);
                    end
                end else if (!pend_reg) begin
                    // shift drained: finish the edit
                    if (op_reg == OP_INSERT) begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_reg[ADDR_W-1:0];
                        mem_wdata = val_reg;
                        len_next  = len_reg + len_t'(1);
                    end else begin
                        len_next  = len_reg - LEN_W'(cnt_reg);
                    end
                    state_next = ST_DONE;
                end
            end

            ST_RDWAIT: begin
                rd_next    = rdata_reg;
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next = 1'b1;
                    macc_next   = acc_reg;
                    mrd_next    = WORD_W'(rd_reg);
                    mlen_next   = NLEN_W'(len_reg);
                    state_next  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            cap_reg    <= CAP_RESET;
            moves_reg  <= '0;
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            macc_reg   <= 1'b0;
            mrd_reg    <= '0;
            mlen_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            moves_reg  <= moves_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
            macc_reg   <= macc_next;
            mrd_reg    <= mrd_next;
            mlen_reg   <= mlen_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        pos_reg  <= pos_next;
        cnt_reg  <= cnt_next;
        val_reg  <= val_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        acc_reg  <= acc_next;
        rd_reg   <= rd_next;
    end

    // Entry memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule : positional_insert_delete_list

`default_nettype wire
